[rtl/wpr_pkg.sv]
package wpr_pkg;

	// field and register widths
	localparam int CmdW     = 2;
	localparam int TickW    = 32;
	localparam int CircW    = 12;
	localparam int DebW     = 10;
	localparam int PerW     = 7;
	localparam int SpeedW   = 21;
	localparam int DistW    = 48;
	localparam int CntW     = 32;
	localparam int CfgIdxW  = 2;
	localparam int CfgDataW = 12;

	// register reset values
	localparam logic [CircW-1:0] CircReset   = 12'd2100;
	localparam logic [DebW-1:0]  DebReset    = 10'd20;
	localparam logic [PerW-1:0]  PeriodReset = 7'd10;

	// mm per ms to 0.01 km/h
	localparam int MmPerKm     = 1000000;
	localparam int MsPerHour   = 3600000;
	localparam int CentiPerKmh = 100;
	localparam int SpeedScale  = MsPerHour / (MmPerKm / CentiPerKmh);
	localparam int ScaleW      = $clog2(SpeedScale + 1);

	// dividend widths for the two divisions
	localparam int SpeedNumW = CircW + ScaleW;
	localparam int AvgNumW   = DistW + ScaleW;
	localparam int QCntW     = $clog2(SpeedW);

	localparam logic [SpeedW-1:0] SpeedMax = {SpeedW{1'b1}};

	typedef enum logic [CmdW-1:0] {
		CMD_REED        = 2'd0,
		CMD_SYNC_START  = 2'd1,
		CMD_SYNC_FINISH = 2'd2,
		CMD_STOP        = 2'd3
	} cmd_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_CIRC     = 2'd0,
		REG_DEBOUNCE = 2'd1,
		REG_PERIOD   = 2'd2
	} reg_idx_t;

endpackage

[rtl/wheel_pulse_ride_metrics.sv]
// Channel  Direction  Handshake             Payload
// input    in         in_valid / in_stall   command, tick_count, clear_trip
// output   out        out_valid / out_stall accepted .. ride_time_ms (one per input)
// config   in         cfg_we                cfg_index, cfg_data
//
// An accepted reed event passes, in order, the interval multiply and checks, 21
// steps of one restoring divider (one quotient bit per cycle) for the current
// speed, the peak and average scaling (ST_AVG_X9, ST_AVG_X40, ST_AVG_SAT), 21
// more steps for the trip average and the load of the output register.
// A zero ride time or a saturated average skips the second divide. Other commands
// and events rejected before the interval check go from ST_EXEC to ST_FIN,
// those rejected at the debounce check from ST_CHECK. in_stall is high while an
// item is in work and while the finished item waits for a full output register.
// The result sits in an output register, so the next transfer on the input is
// taken while it waits. arst_n clears all metrics and loads register defaults.
module wheel_pulse_ride_metrics (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [wpr_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [wpr_pkg::CfgDataW-1:0]  cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [wpr_pkg::CmdW-1:0]      command,
	input  logic [wpr_pkg::TickW-1:0]     tick_count,
	input  logic                          clear_trip,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          accepted,
	output logic                          ride_started,
	output logic [wpr_pkg::SpeedW-1:0]    speed_centi_kmh,
	output logic [wpr_pkg::SpeedW-1:0]    avg_speed_centi_kmh,
	output logic [wpr_pkg::SpeedW-1:0]    max_speed_centi_kmh,
	output logic [wpr_pkg::DistW-1:0]     trip_distance_mm,
	output logic [wpr_pkg::DistW-1:0]     odometer_mm,
	output logic [wpr_pkg::CntW-1:0]      rotation_count,
	output logic [wpr_pkg::CntW-1:0]      ride_time_ms
);
	import wpr_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXEC,
		ST_CHECK,
		ST_DIV_SPEED,
		ST_AVG_X9,
		ST_AVG_X40,
		ST_AVG_SAT,
		ST_DIV_AVG,
		ST_FIN
	} state_t;

	state_t state_q;

	// configuration
	logic [CircW-1:0] circ_q;
	logic [DebW-1:0]  debounce_q;
	logic [PerW-1:0]  period_q;

	// ride state
	logic [TickW-1:0]  last_tick_q;
	logic              moving_q;
	logic              blocked_q;
	logic [CntW-1:0]   rotations_q;
	logic [CntW-1:0]   mtime_q;
	logic [DistW-1:0]  trip_q;
	logic [DistW-1:0]  total_q;
	logic [SpeedW-1:0] cur_speed_q;
	logic [SpeedW-1:0] avg_speed_q;
	logic [SpeedW-1:0] peak_q;
	logic              acc_q;
	logic              started_q;

	// captured item and datapath
	logic [CmdW-1:0]    cmd_q;
	logic [TickW-1:0]   tick_q;
	logic               clr_q;
	logic [TickW-1:0]   ms_q;
	logic [AvgNumW-1:0] num_q;
	logic [CntW-1:0]    rem_q;
	logic [CntW-1:0]    den_q;
	logic [SpeedW-1:0]  dvd_q;
	logic [QCntW-1:0]   cnt_q;

	// output register
	logic              out_valid_q;
	logic              out_acc_q;
	logic              out_started_q;
	logic [SpeedW-1:0] out_speed_q;
	logic [SpeedW-1:0] out_avg_q;
	logic [SpeedW-1:0] out_peak_q;
	logic [DistW-1:0]  out_trip_q;
	logic [DistW-1:0]  out_total_q;
	logic [CntW-1:0]   out_rot_q;
	logic [CntW-1:0]   out_time_q;

	logic              in_xfer;
	logic              out_free;
	logic              reed_ok;
	logic [CntW:0]     trial;
	logic              q_bit;
	logic [CntW-1:0]   rem_next;
	logic              div_last;
	logic [SpeedNumW-1:0] speed_num;
	logic [AvgNumW-1:0]   sat_limit;

	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// reject blocked, zero and repeated ticks
	assign reed_ok = !blocked_q && (tick_q != '0) && (tick_q != last_tick_q);

	// shared divider step: one quotient bit per cycle
	assign trial    = {rem_q, dvd_q[SpeedW-1]};
	assign q_bit    = (trial >= {1'b0, den_q});
	assign rem_next = q_bit ? CntW'(trial - {1'b0, den_q}) : CntW'(trial);
	assign div_last = (cnt_q == QCntW'(SpeedW - 1));

	assign speed_num = SpeedNumW'(circ_q) * SpeedNumW'(SpeedScale);
	assign sat_limit = AvgNumW'({mtime_q, {SpeedW{1'b0}}});

	// sequencer, metrics, config and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			circ_q      <= CircReset;
			debounce_q  <= DebReset;
			period_q    <= PeriodReset;
			last_tick_q <= '0;
			moving_q    <= 1'b0;
			blocked_q   <= 1'b0;
			rotations_q <= '0;
			mtime_q     <= '0;
			trip_q      <= '0;
			total_q     <= '0;
			cur_speed_q <= '0;
			avg_speed_q <= '0;
			peak_q      <= '0;
			acc_q       <= 1'b0;
			started_q   <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// write configuration
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_CIRC:     circ_q     <= cfg_data[CircW-1:0];
					REG_DEBOUNCE: debounce_q <= cfg_data[DebW-1:0];
					REG_PERIOD:   period_q   <= cfg_data[PerW-1:0];
					default: ;
				endcase
			end

			// load a finished result, drop it once transferred
			if (state_q == ST_FIN && out_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (in_xfer)
						state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					acc_q     <= 1'b0;
					started_q <= 1'b0;
					state_q   <= (cmd_t'(cmd_q) == CMD_REED && reed_ok) ? ST_CHECK : ST_FIN;
					case (cmd_t'(cmd_q))
						CMD_SYNC_START: blocked_q <= 1'b1;
						CMD_SYNC_FINISH: begin
							if (clr_q) begin
								rotations_q <= '0;
								mtime_q     <= '0;
								trip_q      <= '0;
								cur_speed_q <= '0;
								avg_speed_q <= '0;
								last_tick_q <= '0;
							end
							blocked_q <= 1'b0;
						end
						CMD_STOP: moving_q <= 1'b0;
						default: ;
					endcase
				end
				ST_CHECK: begin
					if (ms_q > TickW'(debounce_q)) begin
						acc_q       <= 1'b1;
						last_tick_q <= tick_q;
						started_q   <= !moving_q;
						if (moving_q)
							mtime_q <= mtime_q + ms_q;
						moving_q    <= 1'b1;
						rotations_q <= rotations_q + CntW'(1);
						trip_q      <= trip_q + DistW'(circ_q);
						total_q     <= total_q + DistW'(circ_q);
						cnt_q       <= '0;
						state_q     <= ST_DIV_SPEED;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_DIV_SPEED: begin
					cnt_q <= cnt_q + QCntW'(1);
					if (div_last) begin
						cur_speed_q <= {dvd_q[SpeedW-2:0], q_bit};
						state_q     <= ST_AVG_X9;
					end
				end
				ST_AVG_X9: begin
					// track peak against the fresh speed
					if (cur_speed_q > peak_q)
						peak_q <= cur_speed_q;
					if (mtime_q == '0) begin
						avg_speed_q <= '0;
						state_q     <= ST_FIN;
					end else begin
						state_q <= ST_AVG_X40;
					end
				end
				ST_AVG_X40: state_q <= ST_AVG_SAT;
				ST_AVG_SAT: begin
					cnt_q <= '0;
					if (num_q >= sat_limit) begin
						avg_speed_q <= SpeedMax;
						state_q     <= ST_FIN;
					end else begin
						state_q <= ST_DIV_AVG;
					end
				end
				ST_DIV_AVG: begin
					cnt_q <= cnt_q + QCntW'(1);
					if (div_last) begin
						avg_speed_q <= {dvd_q[SpeedW-2:0], q_bit};
						state_q     <= ST_FIN;
					end
				end
				ST_FIN: begin
					// hand over when the output register is free
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload: captured item, divider datapath, output fields
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_q  <= command;
			tick_q <= tick_count;
			clr_q  <= clear_trip;
		end
		case (state_q)
			ST_EXEC: ms_q <= TickW'((tick_q - last_tick_q) * TickW'(period_q));
			ST_CHECK: begin
				rem_q <= '0;
				den_q <= ms_q;
				dvd_q <= SpeedW'(speed_num);
			end
			ST_DIV_SPEED, ST_DIV_AVG: begin
				rem_q <= rem_next;
				dvd_q <= {dvd_q[SpeedW-2:0], q_bit};
			end
			ST_AVG_X9: num_q <= AvgNumW'(trip_q) + (AvgNumW'(trip_q) << 3);
			ST_AVG_X40: num_q <= (num_q + (num_q << 2)) << 3;
			ST_AVG_SAT: begin
				rem_q <= CntW'(num_q[AvgNumW-1:SpeedW]);
				den_q <= mtime_q;
				dvd_q <= num_q[SpeedW-1:0];
			end
			ST_FIN: begin
				if (out_free) begin
					out_acc_q     <= acc_q;
					out_started_q <= started_q;
					out_speed_q   <= cur_speed_q;
					out_avg_q     <= avg_speed_q;
					out_peak_q    <= peak_q;
					out_trip_q    <= trip_q;
					out_total_q   <= total_q;
					out_rot_q     <= rotations_q;
					out_time_q    <= mtime_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid           = out_valid_q;
	assign accepted            = out_acc_q;
	assign ride_started        = out_started_q;
	assign speed_centi_kmh     = out_speed_q;
	assign avg_speed_centi_kmh = out_avg_q;
	assign max_speed_centi_kmh = out_peak_q;
	assign trip_distance_mm    = out_trip_q;
	assign odometer_mm         = out_total_q;
	assign rotation_count      = out_rot_q;
	assign ride_time_ms        = out_time_q;

	// a ride starts only from an accepted interval check
	a_moving_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(moving_q) |-> $past(state_q == ST_CHECK))
		else $error("moving set outside the interval check");

	// the peak never trails the current speed once a result is shown
	a_peak_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (max_speed_centi_kmh >= speed_centi_kmh))
		else $error("peak speed below current speed");

	// a start flag only comes with an accepted event
	a_start_acc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ride_started |-> accepted)
		else $error("ride start without accepted event");

	// a transfer in always begins execution next cycle
	a_in_exec: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (state_q == ST_EXEC))
		else $error("input transfer did not start execution");

endmodule

[sim/ride_metrics_checker.sv]
module ride_metrics_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [wpr_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [wpr_pkg::CfgDataW-1:0]  cfg_data,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic [wpr_pkg::CmdW-1:0]      command,
	input  logic [wpr_pkg::TickW-1:0]     tick_count,
	input  logic                          clear_trip,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic                          accepted,
	input  logic                          ride_started,
	input  logic [wpr_pkg::SpeedW-1:0]    speed_centi_kmh,
	input  logic [wpr_pkg::SpeedW-1:0]    avg_speed_centi_kmh,
	input  logic [wpr_pkg::SpeedW-1:0]    max_speed_centi_kmh,
	input  logic [wpr_pkg::DistW-1:0]     trip_distance_mm,
	input  logic [wpr_pkg::DistW-1:0]     odometer_mm,
	input  logic [wpr_pkg::CntW-1:0]      rotation_count,
	input  logic [wpr_pkg::CntW-1:0]      ride_time_ms,
	output int                            mismatches,
	output int                            results_owed
);
	timeunit 1ns;
	timeprecision 1ps;
	import wpr_pkg::*;

	typedef struct packed {
		logic              accepted;
		logic              ride_started;
		logic [SpeedW-1:0] speed;
		logic [SpeedW-1:0] avg_speed;
		logic [SpeedW-1:0] max_speed;
		logic [DistW-1:0]  trip;
		logic [DistW-1:0]  odometer;
		logic [CntW-1:0]   rotations;
		logic [CntW-1:0]   ride_time;
	} ride_metrics_t;

	// register copies
	logic [CircW-1:0] circ_mm;
	logic [DebW-1:0]  debounce_ms;
	logic [PerW-1:0]  period_ms;

	// ride state
	logic [TickW-1:0]  last_tick;
	logic              moving;
	logic              sync_blocked;
	logic [CntW-1:0]   rotations;
	logic [CntW-1:0]   moving_ms;
	logic [DistW-1:0]  trip_mm;
	logic [DistW-1:0]  total_mm;
	logic [SpeedW-1:0] speed_now;
	logic [SpeedW-1:0] speed_avg;
	logic [SpeedW-1:0] speed_peak;

	ride_metrics_t expected_metrics[$];
	int errors = 0;

	assign mismatches = errors;

	function automatic logic [SpeedW-1:0] clamp_speed(logic [63:0] v);
		return (v > 64'(SpeedMax)) ? SpeedMax : v[SpeedW-1:0];
	endfunction

	// advance the ride state by one command, return the metrics it reports
	function automatic ride_metrics_t advance_ride(cmd_t cmd, logic [TickW-1:0] tick,
			logic clr);
		ride_metrics_t r;
		logic [63:0] delta;
		logic [63:0] span;
		logic [63:0] num;
		logic [31:0] ms;
		r = '0;
		case (cmd)
			CMD_SYNC_START: begin
				sync_blocked = 1'b1;
			end
			CMD_SYNC_FINISH: begin
				if (clr) begin
					rotations = '0;
					moving_ms = '0;
					trip_mm   = '0;
					speed_now = '0;
					speed_avg = '0;
					last_tick = '0;
				end
				sync_blocked = 1'b0;
			end
			CMD_STOP: begin
				moving = 1'b0;
			end
			default: begin
				if (!sync_blocked && tick != '0 && tick != last_tick) begin
					delta = {32'd0, tick - last_tick};
					span  = delta * {57'd0, period_ms};
					ms    = span[31:0];
					if (ms > {22'd0, debounce_ms}) begin
						r.accepted = 1'b1;
						last_tick  = tick;
						if (!moving)
							r.ride_started = 1'b1;
						else
							moving_ms = moving_ms + ms;
						moving    = 1'b1;
						rotations = rotations + 1'b1;
						num       = {52'd0, circ_mm};
						speed_now = clamp_speed((num * SpeedScale) / {32'd0, ms});
						trip_mm   = trip_mm + circ_mm;
						total_mm  = total_mm + circ_mm;
						num       = {16'd0, trip_mm};
						if (moving_ms == '0)
							speed_avg = '0;
						else
							speed_avg = clamp_speed((num * SpeedScale) / {32'd0, moving_ms});
						if (speed_now > speed_peak)
							speed_peak = speed_now;
					end
				end
			end
		endcase
		r.speed     = speed_now;
		r.avg_speed = speed_avg;
		r.max_speed = speed_peak;
		r.trip      = trip_mm;
		r.odometer  = total_mm;
		r.rotations = rotations;
		r.ride_time = moving_ms;
		return r;
	endfunction

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	// track config writes, score output transfers, predict input transfers
	always @(posedge clk or negedge arst_n) begin
		ride_metrics_t want;
		ride_metrics_t got;
		if (!arst_n) begin
			circ_mm      = CircReset;
			debounce_ms  = DebReset;
			period_ms    = PeriodReset;
			last_tick    = '0;
			moving       = 1'b0;
			sync_blocked = 1'b0;
			rotations    = '0;
			moving_ms    = '0;
			trip_mm      = '0;
			total_mm     = '0;
			speed_now    = '0;
			speed_avg    = '0;
			speed_peak   = '0;
			expected_metrics.delete();
			results_owed <= 0;
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_CIRC:     circ_mm     = cfg_data[CircW-1:0];
					REG_DEBOUNCE: debounce_ms = cfg_data[DebW-1:0];
					REG_PERIOD:   period_ms   = cfg_data[PerW-1:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				got = {accepted, ride_started, speed_centi_kmh, avg_speed_centi_kmh,
					max_speed_centi_kmh, trip_distance_mm, odometer_mm, rotation_count,
					ride_time_ms};
				if (expected_metrics.size() == 0) begin
					$error("result transfer with no command outstanding");
					errors++;
				end else begin
					want = expected_metrics.pop_front();
					check_field("accepted", want.accepted, got.accepted);
					check_field("ride_started", want.ride_started, got.ride_started);
					check_field("speed_centi_kmh", want.speed, got.speed);
					check_field("avg_speed_centi_kmh", want.avg_speed, got.avg_speed);
					check_field("max_speed_centi_kmh", want.max_speed, got.max_speed);
					check_field("trip_distance_mm", want.trip, got.trip);
					check_field("odometer_mm", want.odometer, got.odometer);
					check_field("rotation_count", want.rotations, got.rotations);
					check_field("ride_time_ms", want.ride_time, got.ride_time);
				end
			end
			if (in_valid && !in_stall)
				expected_metrics.push_back(advance_ride(cmd_t'(command), tick_count,
					clear_trip));
			results_owed <= expected_metrics.size();
		end
	end

endmodule

[sim/testbench.sv]
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import wpr_pkg::*;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;
	logic                in_valid;
	logic                in_stall;
	logic [CmdW-1:0]     command;
	logic [TickW-1:0]    tick_count;
	logic                clear_trip;
	logic                out_valid;
	logic                out_stall;
	logic                accepted;
	logic                ride_started;
	logic [SpeedW-1:0]   speed_centi_kmh;
	logic [SpeedW-1:0]   avg_speed_centi_kmh;
	logic [SpeedW-1:0]   max_speed_centi_kmh;
	logic [DistW-1:0]    trip_distance_mm;
	logic [DistW-1:0]    odometer_mm;
	logic [CntW-1:0]     rotation_count;
	logic [CntW-1:0]     ride_time_ms;
	int                  mismatches;
	int                  results_owed;

	// stimulus bookkeeping
	int               commands_sent = 0;
	bit               in_calm = 1'b0;
	bit               out_calm = 1'b0;
	logic [TickW-1:0] tick_now;
	logic [DebW-1:0]  deb_now = DebReset;
	logic [PerW-1:0]  per_now = PeriodReset;

	wheel_pulse_ride_metrics dut (.*);

	ride_metrics_checker scoreboard (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(7_200_000);
		$display("FAIL");
		$finish;
	end

	// present one command and hold it until the transfer
	task automatic send_cmd(cmd_t cmd, logic [TickW-1:0] tick, logic clr);
		int gap;
		if ($urandom_range(0, 63) == 0)
			in_calm = !in_calm;
		gap = in_calm ? 0 : $urandom_range(0, 13);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		command    <= cmd;
		tick_count <= tick;
		clear_trip <= clr;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		commands_sent++;
	endtask

	// drop valid and wait until every result has come back
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_owed != 0) @(posedge clk);
	endtask

	task automatic program_regs(logic [CfgDataW-1:0] circ, logic [CfgDataW-1:0] deb,
			logic [CfgDataW-1:0] per);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= REG_CIRC;
		cfg_data  <= circ;
		@(posedge clk);
		cfg_index <= REG_DEBOUNCE;
		cfg_data  <= deb;
		@(posedge clk);
		cfg_index <= REG_PERIOD;
		cfg_data  <= per;
		@(posedge clk);
		cfg_we  <= 1'b0;
		deb_now = deb[DebW-1:0];
		per_now = per[PerW-1:0];
	endtask

	// mostly clean pedaling with random speed, mixed with syncs, stops and noise
	task automatic ride_random(int count);
		int stop_at;
		int pick;
		int blocked_events;
		logic [31:0] min_step;
		stop_at = commands_sent + count;
		while (commands_sent < stop_at) begin
			min_step = (per_now == '0) ? 32'd1 : 32'(deb_now / per_now) + 32'd1;
			pick = $urandom_range(0, 99);
			if (pick < 68) begin
				tick_now = tick_now + min_step + $urandom_range(0, 4 * min_step + 30);
				send_cmd(CMD_REED, tick_now, 1'($urandom_range(0, 1)));
			end else if (pick < 74) begin
				// bounce inside the debounce window or repeat the tick
				tick_now = tick_now + $urandom_range(0, min_step - 1);
				send_cmd(CMD_REED, tick_now, 1'($urandom_range(0, 1)));
			end else if (pick < 77) begin
				send_cmd(CMD_REED, '0, 1'($urandom_range(0, 1)));
			end else if (pick < 80) begin
				tick_now = $urandom;
				send_cmd(CMD_REED, tick_now, 1'($urandom_range(0, 1)));
			end else if (pick < 88) begin
				send_cmd(CMD_SYNC_START, $urandom, 1'($urandom_range(0, 1)));
				blocked_events = $urandom_range(0, 3);
				repeat (blocked_events) begin
					tick_now = tick_now + min_step + $urandom_range(0, 20);
					send_cmd(CMD_REED, tick_now, 1'($urandom_range(0, 1)));
				end
				send_cmd(CMD_SYNC_FINISH, $urandom, 1'($urandom_range(0, 1)));
			end else if (pick < 91) begin
				send_cmd(CMD_SYNC_FINISH, $urandom, 1'($urandom_range(0, 1)));
			end else if (pick < 96) begin
				send_cmd(CMD_STOP, $urandom, 1'($urandom_range(0, 1)));
			end else begin
				// long coast, drives ride time toward wrap
				tick_now = tick_now + $urandom;
				send_cmd(CMD_REED, tick_now, 1'($urandom_range(0, 1)));
			end
		end
	endtask

	// result side: stall for a random number of cycles after each transfer
	initial begin
		int gap;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			if ($urandom_range(0, 63) == 0)
				out_calm = !out_calm;
			gap = out_calm ? 0 : $urandom_range(0, 13);
			if (gap != 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		arst_n     <= 1'b0;
		cfg_we     <= 1'b0;
		cfg_index  <= REG_CIRC;
		cfg_data   <= '0;
		in_valid   <= 1'b0;
		command    <= CMD_REED;
		tick_count <= '0;
		clear_trip <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings, 2100 mm wheel, 20 ms debounce, 10 ms ticks
		send_cmd(CMD_REED, 32'd0, 1'b0);           // zero tick
		send_cmd(CMD_REED, 32'd100, 1'b1);         // ride start
		send_cmd(CMD_REED, 32'd100, 1'b0);         // repeated tick
		send_cmd(CMD_REED, 32'd102, 1'b0);         // exactly at debounce
		send_cmd(CMD_REED, 32'd103, 1'b0);         // just past debounce
		send_cmd(CMD_SYNC_START, 32'hFFFF_FFFF, 1'b0);
		send_cmd(CMD_REED, 32'd200, 1'b0);         // blocked by sync
		send_cmd(CMD_SYNC_FINISH, 32'd0, 1'b0);
		send_cmd(CMD_REED, 32'hFFFF_FFFF, 1'b0);   // interval wraps in ms
		send_cmd(CMD_REED, 32'd5, 1'b1);           // tick wraps past zero
		send_cmd(CMD_STOP, 32'd0, 1'b1);
		send_cmd(CMD_REED, 32'd50, 1'b0);          // restart, no time added
		send_cmd(CMD_SYNC_FINISH, 32'd7, 1'b1);    // finish with no start, clear trip
		send_cmd(CMD_REED, 32'd1, 1'b0);           // debounced after clear
		send_cmd(CMD_REED, 32'h8000_0000, 1'b0);
		send_cmd(CMD_SYNC_START, 32'd0, 1'b1);
		send_cmd(CMD_SYNC_START, 32'd0, 1'b0);
		send_cmd(CMD_SYNC_FINISH, 32'd0, 1'b1);
		send_cmd(CMD_STOP, 32'h5555_AAAA, 1'b0);

		// largest wheel, no debounce, 1 ms ticks: average saturates
		program_regs(12'd4095, 12'd0, 12'd1);
		send_cmd(CMD_REED, 32'h8000_0001, 1'b0);
		send_cmd(CMD_REED, 32'h8000_0002, 1'b0);
		send_cmd(CMD_REED, 32'h8000_0003, 1'b1);
		tick_now = 32'h8000_0003;
		ride_random(220);

		// smallest wheel, longest debounce, slowest ticks
		program_regs(12'd100, 12'd1000, 12'd100);
		ride_random(220);

		program_regs(12'($urandom_range(100, 4095)), 12'($urandom_range(0, 1000)),
			12'($urandom_range(1, 100)));
		ride_random(220);

		// zero tick period: every reed event is rejected
		program_regs(12'd2100, 12'd20, 12'd0);
		ride_random(40);

		// raw register data, upper bits masked off by the block
		program_regs(12'($urandom), 12'($urandom), 12'($urandom));
		ride_random(200);

		program_regs(12'($urandom_range(100, 4095)), 12'($urandom_range(0, 1000)),
			12'($urandom_range(1, 100)));
		ride_random(200);

		// drain, then watch for stray results
		settle();
		repeat (60) @(posedge clk);
		if (mismatches == 0 && results_owed == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
